// File: hw/rtl/midi_poly_voice_allocator_assert.svh
// Assertion macros for the voice allocator.
// Used by the top level; depends on nothing else.
`ifndef MIDI_POLY_VOICE_ALLOCATOR_ASSERT_SVH
`define MIDI_POLY_VOICE_ALLOCATOR_ASSERT_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define MPVA_ASSERT_IMP(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define MPVA_ASSERT_NEXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);

`endif

// File: hw/rtl/mpva_pkg.sv
// Package for the polyphonic voice allocator: types, constants, codes.
// No dependencies.
`default_nettype none
package mpva_pkg;
	localparam int VOICES_DEF = 8;
	localparam int HELD_DEPTH_DEF = 32;
	localparam int CONTROLLERS_DEF = 8;

	localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
	localparam logic [3:0] CMD_NOTE_ON = 4'h9;
	localparam logic [3:0] CMD_CTRL = 4'hB;
	localparam logic [3:0] CMD_BEND = 4'hE;

	localparam logic [1:0] KIND_VOICE = 2'd0;
	localparam logic [1:0] KIND_CTRL = 2'd1;
	localparam logic [1:0] KIND_BEND = 2'd2;

	localparam logic [1:0] REG_CHANNEL = 2'd0;
	localparam logic [1:0] REG_VOICES = 2'd1;
	localparam logic [1:0] REG_CBASE = 2'd2;

	// One held-list entry as it moves along the chain.
	typedef struct packed {
		logic [6:0] note;
		logic [6:0] vel;
		logic [3:0] voice;
		logic       stolen;
	} held_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN_ON, ST_SCAN_OFF, ST_SHIFT, ST_DONE
	} state_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic rotate;     // every cell takes the entry of its right neighbor
		logic shift;      // cells at or above the removed slot take their neighbor
		logic write_tail; // cell at index count takes the new entry
		logic mark;       // set the stolen flag of the selected cell
		logic fix;        // give the selected cell a voice, clear stolen
	} cell_cmd_t;
endpackage
`default_nettype wire

// File: hw/rtl/mpva_cell.sv
// One cell of the held-note chain: holds one entry, passes it left.
// Depends on mpva_pkg.
`default_nettype none
module mpva_cell (
	input  wire logic                clk,
	input  wire mpva_pkg::cell_cmd_t cmd,
	input  wire logic                is_tail,
	input  wire logic                is_above,
	input  wire logic                is_sel,
	input  wire mpva_pkg::held_t     new_entry,
	input  wire logic [3:0]          fix_voice,
	input  wire mpva_pkg::held_t     right,
	output mpva_pkg::held_t          entry
);
	mpva_pkg::held_t entry_q;

	// Entry register: rotate, close a gap, append, or patch the selected entry.
	always_ff @(posedge clk) begin
		if (cmd.rotate) begin
			entry_q <= right;
		end else if (cmd.shift && is_above) begin
			entry_q <= right;
		end else if (cmd.write_tail && is_tail) begin
			entry_q <= new_entry;
		end else if (cmd.mark && is_sel) begin
			entry_q.stolen <= 1'b1;
		end else if (cmd.fix && is_sel) begin
			entry_q.stolen <= 1'b0;
			entry_q.voice <= fix_voice;
		end
	end

	assign entry = entry_q;
endmodule
`default_nettype wire

// File: hw/rtl/midi_poly_voice_allocator.sv
// Top level of the polyphonic voice allocator with note stealing.
// Depends on mpva_pkg, mpva_cell and the assertion macro header.
//
//   port group   direction  transaction marked by
//   message      in         start high while busy low
//   config       in         cfg_we high
//   result       out        out_valid high for one cycle
//
// Held notes sit in a ring of HELD_DEPTH cells that rotates one place per
// cycle, so one lap scans the whole list.
// A note-on keeps busy high through its scan lap and a done state, and its
// result shows in the cycle busy falls; a note-off adds a shift state.
// Controller and bend results show in the cycle after the accepting edge and
// busy stays low. Reset clears voices and count, resets config; not the cells.
// Results cannot be stalled; dropped messages give no result.
`default_nettype none
module midi_poly_voice_allocator #(
	parameter int VOICES = mpva_pkg::VOICES_DEF,
	parameter int HELD_DEPTH = mpva_pkg::HELD_DEPTH_DEF,
	parameter int CONTROLLERS = mpva_pkg::CONTROLLERS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [7:0]  status_byte,
	input  wire logic [6:0]  data_first,
	input  wire logic [6:0]  data_second,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [6:0]  cfg_data,
	output logic             out_valid,
	output logic [1:0]       kind,
	output logic [2:0]       voice_index,
	output logic [6:0]       note_number,
	output logic [6:0]       note_velocity,
	output logic             gate_level,
	output logic [2:0]       controller_index,
	output logic [6:0]       controller_value,
	output logic signed [13:0] bend_value
);
	`include "midi_poly_voice_allocator_assert.svh"

	localparam int HW = $clog2(HELD_DEPTH);
	localparam int CW = $clog2(HELD_DEPTH + 1);
	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

	// Configuration registers.
	logic [3:0] chan_q, vcount_q;
	logic [6:0] cbase_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= '0;
			vcount_q <= 4'd8;
			cbase_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mpva_pkg::REG_CHANNEL: chan_q <= cfg_data[3:0];
				mpva_pkg::REG_VOICES:  vcount_q <= cfg_data[3:0];
				mpva_pkg::REG_CBASE:   cbase_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Voice state.
	logic [6:0] vnote_q [VOICES];
	logic [6:0] vvel_q [VOICES];
	logic [VOICES-1:0] vgate_q;

	// Control state.
	mpva_pkg::state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [HW-1:0] step_q;    // rotation counter within one lap
	logic [6:0] note_q, vel_q;
	logic note_mode_q;        // 1 while handling a note-on
	logic found_q;            // note found (on: duplicate, off: to remove)
	logic have_old_q;         // oldest unstolen entry located
	logic [HW-1:0] old_pos_q; // its position from the head
	logic [3:0] old_voice_q;
	logic [HW-1:0] rem_pos_q; // position of the entry a note-off removes
	logic [3:0] off_voice_q;
	logic off_stolen_q;
	logic have_st_q;          // newest stolen entry located
	logic [HW-1:0] st_pos_q;
	logic [6:0] st_note_q, st_vel_q;

	// Chain of cells, cell 0 is the head; rotation moves cell i+1 into i.
	mpva_pkg::held_t ent [HELD_DEPTH];
	mpva_pkg::held_t rin [HELD_DEPTH];
	mpva_pkg::cell_cmd_t cmd;
	mpva_pkg::held_t new_entry;
	logic [3:0] fix_voice;
	logic [HW-1:0] sel_pos;

	for (genvar g = 0; g < HELD_DEPTH; g++) begin : g_cell
		assign rin[g] = ent[(g + 1) % HELD_DEPTH];
		mpva_cell u_cell (
			.clk(clk), .cmd(cmd),
			.is_tail(count_q == CW'(g)),
			.is_above(HW'(g) >= rem_pos_q),
			.is_sel(HW'(g) == sel_pos),
			.new_entry(new_entry), .fix_voice(fix_voice),
			.right(rin[g]), .entry(ent[g])
		);
	end

	// Position of the entry now at the head during a lap.
	logic [CW-1:0] pos;
	assign pos = CW'(step_q);

	logic head_live;
	assign head_live = (pos < count_q);

	// Free-voice search (priority over at most VOICES gates).
	logic [3:0] limit;
	logic free_found;
	logic [VW-1:0] free_v;
	always_comb begin
		limit = (vcount_q > 4'(VOICES)) ? 4'(VOICES) : vcount_q;
		free_found = 1'b0;
		free_v = '0;
		for (int v = VOICES - 1; v >= 0; v--) begin
			if (4'(v) < limit && !vgate_q[v]) begin
				free_found = 1'b1;
				free_v = VW'(v);
			end
		end
	end

	// Message decode.
	logic is_chan, cmd_on, cmd_off, cmd_ctl, cmd_bend;
	logic [7:0] cdiff;
	always_comb begin
		is_chan = status_byte[3:0] == chan_q;
		cmd_on = is_chan && status_byte[7:4] == mpva_pkg::CMD_NOTE_ON && data_second != '0;
		cmd_off = is_chan && !cmd_on && (status_byte[7:4] == mpva_pkg::CMD_NOTE_ON ||
			status_byte[7:4] == mpva_pkg::CMD_NOTE_OFF);
		cmd_ctl = is_chan && status_byte[7:4] == mpva_pkg::CMD_CTRL;
		cmd_bend = is_chan && status_byte[7:4] == mpva_pkg::CMD_BEND;
		cdiff = {1'b0, data_first} - {1'b0, cbase_q};
	end

	logic accept;
	assign accept = start && !busy;
	logic lap_end;
	assign lap_end = step_q == HW'(HELD_DEPTH - 1);

	// A note-on completes when the lap ends: decide allocation.
	logic on_ok;
	logic [3:0] on_voice;
	always_comb begin
		on_ok = 1'b0;
		on_voice = 4'(free_v);
		if (!found_q && count_q < CW'(HELD_DEPTH)) begin
			if (free_found) begin
				on_ok = 1'b1;
			end else if (have_old_q && old_voice_q < 4'(VOICES)) begin
				on_ok = 1'b1;
				on_voice = old_voice_q;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpva_pkg::ST_IDLE: begin
				if (accept && cmd_on) state_d = mpva_pkg::ST_SCAN_ON;
				else if (accept && cmd_off) state_d = mpva_pkg::ST_SCAN_OFF;
			end
			mpva_pkg::ST_SCAN_ON: if (lap_end) state_d = mpva_pkg::ST_DONE;
			mpva_pkg::ST_SCAN_OFF: if (lap_end) state_d = mpva_pkg::ST_SHIFT;
			mpva_pkg::ST_SHIFT: begin
				if (!found_q || off_stolen_q || off_voice_q >= 4'(VOICES))
					state_d = mpva_pkg::ST_IDLE;
				else state_d = mpva_pkg::ST_DONE;
			end
			mpva_pkg::ST_DONE: state_d = mpva_pkg::ST_IDLE;
			default: state_d = mpva_pkg::ST_IDLE;
		endcase
	end

	// Cell commands. Scans rotate the ring one full lap; a note-off closes the
	// gap in one shift; the final cycle appends, marks or hands a voice back.
	always_comb begin
		cmd = '0;
		sel_pos = old_pos_q;
		new_entry.note = note_q;
		new_entry.vel = vel_q;
		new_entry.voice = on_voice;
		new_entry.stolen = 1'b0;
		fix_voice = off_voice_q;
		unique case (state_q)
			mpva_pkg::ST_SCAN_ON, mpva_pkg::ST_SCAN_OFF: cmd.rotate = 1'b1;
			mpva_pkg::ST_SHIFT: cmd.shift = found_q;
			mpva_pkg::ST_DONE: begin
				if (note_mode_q) begin
					cmd.write_tail = on_ok;
					cmd.mark = on_ok && !free_found;
				end else begin
					cmd.fix = have_st_q;
					sel_pos = st_pos_q;
				end
			end
			default: ;
		endcase
	end

	// Main sequencing registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpva_pkg::ST_IDLE;
			count_q <= '0;
			step_q <= '0;
			vgate_q <= '0;
			for (int v = 0; v < VOICES; v++) begin
				vnote_q[v] <= '0;
				vvel_q[v] <= '0;
			end
			note_q <= '0;
			vel_q <= '0;
			note_mode_q <= 1'b0;
			found_q <= 1'b0;
			have_old_q <= 1'b0;
			old_pos_q <= '0;
			old_voice_q <= '0;
			rem_pos_q <= '0;
			off_voice_q <= '0;
			off_stolen_q <= 1'b0;
			have_st_q <= 1'b0;
			st_pos_q <= '0;
			st_note_q <= '0;
			st_vel_q <= '0;
			out_valid <= 1'b0;
			kind <= '0;
			voice_index <= '0;
			note_number <= '0;
			note_velocity <= '0;
			gate_level <= 1'b0;
			controller_index <= '0;
			controller_value <= '0;
			bend_value <= '0;
		end else begin
			state_q <= state_d;
			out_valid <= 1'b0;
			unique case (state_q)
				mpva_pkg::ST_IDLE: begin
					step_q <= '0;
					found_q <= 1'b0;
					have_old_q <= 1'b0;
					have_st_q <= 1'b0;
					if (accept) begin
						note_q <= data_first;
						vel_q <= data_second;
						note_mode_q <= cmd_on;
						if (cmd_ctl && cdiff < 8'(CONTROLLERS)) begin
							out_valid <= 1'b1;
							kind <= mpva_pkg::KIND_CTRL;
							voice_index <= '0;
							note_number <= '0;
							note_velocity <= '0;
							gate_level <= 1'b0;
							controller_index <= cdiff[2:0];
							controller_value <= data_second;
							bend_value <= '0;
						end else if (cmd_bend) begin
							out_valid <= 1'b1;
							kind <= mpva_pkg::KIND_BEND;
							voice_index <= '0;
							note_number <= '0;
							note_velocity <= '0;
							gate_level <= 1'b0;
							controller_index <= '0;
							controller_value <= '0;
							bend_value <= {data_second, data_first} - 14'h2000;
						end
					end
				end
				mpva_pkg::ST_SCAN_ON, mpva_pkg::ST_SCAN_OFF: begin
					step_q <= lap_end ? '0 : step_q + HW'(1);
					if (state_q == mpva_pkg::ST_SCAN_ON && head_live) begin
						if (ent[0].note == note_q) found_q <= 1'b1;
						if (!have_old_q && !ent[0].stolen) begin
							have_old_q <= 1'b1;
							old_pos_q <= step_q;
							old_voice_q <= ent[0].voice;
						end
					end
					if (state_q == mpva_pkg::ST_SCAN_OFF && head_live) begin
						if (ent[0].note == note_q && !found_q) begin
							found_q <= 1'b1;
							rem_pos_q <= step_q;
							off_voice_q <= ent[0].voice;
							off_stolen_q <= ent[0].stolen;
						end
						// The last stolen entry seen is the newest one.
						if (ent[0].stolen) begin
							have_st_q <= 1'b1;
							st_pos_q <= step_q;
							st_note_q <= ent[0].note;
							st_vel_q <= ent[0].vel;
						end
					end
				end
				mpva_pkg::ST_SHIFT: begin
					if (found_q) begin
						count_q <= count_q - CW'(1);
						if (have_st_q && st_pos_q > rem_pos_q) st_pos_q <= st_pos_q - HW'(1);
					end
				end
				mpva_pkg::ST_DONE: begin
					if (note_mode_q) begin
						if (on_ok) begin
							count_q <= count_q + CW'(1);
							vnote_q[on_voice[VW-1:0]] <= note_q;
							vvel_q[on_voice[VW-1:0]] <= vel_q;
							vgate_q[on_voice[VW-1:0]] <= 1'b1;
							out_valid <= 1'b1;
							kind <= mpva_pkg::KIND_VOICE;
							voice_index <= 3'(on_voice);
							note_number <= note_q;
							note_velocity <= vel_q;
							gate_level <= 1'b1;
							controller_index <= '0;
							controller_value <= '0;
							bend_value <= '0;
						end
					end else begin
						out_valid <= 1'b1;
						kind <= mpva_pkg::KIND_VOICE;
						voice_index <= 3'(off_voice_q);
						controller_index <= '0;
						controller_value <= '0;
						bend_value <= '0;
						if (have_st_q) begin
							vnote_q[off_voice_q[VW-1:0]] <= st_note_q;
							vvel_q[off_voice_q[VW-1:0]] <= st_vel_q;
							vgate_q[off_voice_q[VW-1:0]] <= 1'b1;
							note_number <= st_note_q;
							note_velocity <= st_vel_q;
							gate_level <= 1'b1;
						end else begin
							vgate_q[off_voice_q[VW-1:0]] <= 1'b0;
							note_number <= vnote_q[off_voice_q[VW-1:0]];
							note_velocity <= vvel_q[off_voice_q[VW-1:0]];
							gate_level <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign busy = state_q != mpva_pkg::ST_IDLE;

	`MPVA_ASSERT_NEXT(a_note_busy, accept && (cmd_on || cmd_off), busy, "note message not busy")
	`MPVA_ASSERT_IMP(a_count_range, 1'b1, count_q <= CW'(HELD_DEPTH), "held count overflow")
	`MPVA_ASSERT_NEXT(a_done_idle, state_q == mpva_pkg::ST_DONE, state_q == mpva_pkg::ST_IDLE, "done not followed by idle")
endmodule
`default_nettype wire
